FILE: hdl/kmsd_pkg.sv
// Package for the keypad matrix scanner: shared constants and helpers.
// No dependencies.
`timescale 1ns / 1ps
package kmsd_pkg;

  localparam int DEF_NUM_ROWS = 4;
  localparam int DEF_NUM_COLS = 4;
  localparam int CNT_W        = 4;   // per-key press / release count
  localparam int LEVEL_W      = 4;   // column level bus
  localparam int DRIVE_W      = 4;   // row drive lines
  localparam int SROW_W       = 2;   // reported row index
  localparam int OUT_KEYS     = 16;  // keys visible on the outputs
  localparam logic [CNT_W-1:0] DEBOUNCE_RESET = CNT_W'(3);

  // A threshold of zero behaves as one.
  function automatic logic [CNT_W-1:0] eff_threshold(input logic [CNT_W-1:0] dt);
    eff_threshold = (dt == '0) ? CNT_W'(1) : dt;
  endfunction

endpackage

FILE: hdl/keypad_matrix_scan_debounce_top.sv
// Keypad matrix scanner top: input stage, row memory, update and output register.
// Depends on kmsd_pkg, kmsd_rowmem and kmsd_update.
`timescale 1ns / 1ps
// One beat on the input carries the column levels sampled while the current
// row was driven low; one result beat comes back per input beat. The block
// takes one beat per cycle as long as out_ready does not hold the output back: on
// acceptance the row's count entry is read from a memory with a single read
// port into the update stage, where it is updated and written back while the
// result is loaded into the output register, so a result passes the update
// stage and then the output register before it is offered. When the
// same row is read in the cycle it is written back
// (single-row configurations) the fresh word is forwarded. Held flags sit in
// flip-flops since all of them are reported every beat. Per-row valid bits make
// the memory read as zero after reset, so there is no clearing pass. The
// debounce threshold may only be written while idle; zero acts as one.
module keypad_matrix_scan_debounce_top #(
  parameter int NUM_ROWS = kmsd_pkg::DEF_NUM_ROWS,
  parameter int NUM_COLS = kmsd_pkg::DEF_NUM_COLS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmsd_pkg::CNT_W-1:0]    cfg_debounce_ticks,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmsd_pkg::LEVEL_W-1:0]  in_column_levels,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kmsd_pkg::DRIVE_W-1:0]  out_row_drive,
  output logic [kmsd_pkg::SROW_W-1:0]   out_scanned_row,
  output logic [kmsd_pkg::OUT_KEYS-1:0] out_press_events,
  output logic [kmsd_pkg::OUT_KEYS-1:0] out_keys_held
);
  import kmsd_pkg::*;

  localparam int ROW_W    = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int NUM_KEYS = NUM_ROWS * NUM_COLS;
  localparam int WORD_W   = NUM_COLS * 2 * CNT_W;

  // config register
  logic [CNT_W-1:0] dt_r;

  // input side
  logic [ROW_W-1:0] cur_row_r;
  logic             in_acc;

  // update stage
  logic             s1_vld_r, s1_adv;
  logic [ROW_W-1:0] s1_row_r, s1_row_nxt;
  logic [LEVEL_W-1:0] s1_lvl_r;
  logic             byp_r;
  logic [WORD_W-1:0] byp_data_r;
  logic [WORD_W-1:0] rd_word, cur_word, new_word;
  logic [NUM_COLS-1:0] held_row, held_new, evt_row;
  logic [NUM_KEYS-1:0] held_r, held_nxt, evt_all;

  // output register
  logic                out_valid_r;
  logic [DRIVE_W-1:0]  drive_r, drive_nxt;
  logic [SROW_W-1:0]   srow_r;
  logic [OUT_KEYS-1:0] evt_r, evt_nxt, hold_out_r, hold_out_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= DEBOUNCE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      dt_r <= cfg_debounce_ticks;
    end
  end

  assign s1_adv   = s1_vld_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_vld_r || s1_adv;
  assign in_acc   = in_valid && in_ready;

  function automatic logic [ROW_W-1:0] row_inc(input logic [ROW_W-1:0] r);
    row_inc = (int'(r) == NUM_ROWS - 1) ? '0 : r + ROW_W'(1);
  endfunction

  assign s1_row_nxt = row_inc(s1_row_r);

  kmsd_rowmem #(
    .NUM_ROWS (NUM_ROWS),
    .WORD_W   (WORD_W),
    .ADDR_W   (ROW_W)
  ) u_rowmem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_addr (cur_row_r),
    .rd_data (rd_word),
    .wr_en   (s1_adv),
    .wr_addr (s1_row_r),
    .wr_data (new_word)
  );

  // Control: row pointer, stage valid, bypass of a same-row write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      s1_vld_r  <= 1'b0;
      byp_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        cur_row_r <= row_inc(cur_row_r);
        s1_vld_r  <= 1'b1;
        byp_r     <= s1_adv && (s1_row_r == cur_row_r);
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_row_r   <= cur_row_r;
      s1_lvl_r   <= in_column_levels;
      byp_data_r <= new_word;
    end
  end

  assign cur_word = byp_r ? byp_data_r : rd_word;
  assign held_row = held_r[int'(s1_row_r)*NUM_COLS +: NUM_COLS];

  kmsd_update #(
    .NUM_COLS (NUM_COLS)
  ) u_update (
    .levels   (s1_lvl_r),
    .thr      (eff_threshold(dt_r)),
    .word_in  (cur_word),
    .held_in  (held_row),
    .word_out (new_word),
    .held_out (held_new),
    .evt_out  (evt_row)
  );

  // spread the row's results over the key vectors
  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_key
    always_comb begin
      if (int'(s1_row_r) == k / NUM_COLS) begin
        held_nxt[k] = held_new[k % NUM_COLS];
        evt_all[k]  = evt_row[k % NUM_COLS];
      end else begin
        held_nxt[k] = held_r[k];
        evt_all[k]  = 1'b0;
      end
    end
  end

  for (genvar i = 0; i < OUT_KEYS; i++) begin : g_out
    if (i < NUM_KEYS) begin : g_have
      assign evt_nxt[i]      = evt_all[i];
      assign hold_out_nxt[i] = held_nxt[i];
    end else begin : g_none
      assign evt_nxt[i]      = 1'b0;
      assign hold_out_nxt[i] = 1'b0;
    end
  end

  for (genvar j = 0; j < DRIVE_W; j++) begin : g_drv
    assign drive_nxt[j] = (int'(s1_row_nxt) != j);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        held_r      <= held_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      drive_r    <= drive_nxt;
      srow_r     <= SROW_W'(s1_row_r);
      evt_r      <= evt_nxt;
      hold_out_r <= hold_out_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row_drive    = drive_r;
  assign out_scanned_row  = srow_r;
  assign out_press_events = evt_r;
  assign out_keys_held    = hold_out_r;

  // A stalled update stage keeps its row.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_adv |=> s1_vld_r && $stable(s1_row_r))
    else $error("update stage lost its beat while stalled");

  // Every accepted beat reaches the update stage.
  a_in_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> s1_vld_r)
    else $error("accepted beat did not enter update stage");

  // Back-to-back beats on the same row are forwarded through the bypass.
  a_byp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && s1_adv && (s1_row_r == cur_row_r) |=> byp_r && s1_vld_r)
    else $error("same-row write-back not forwarded");

  // While the output is valid, press events are a subset of held keys.
  a_evt_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((evt_r & ~hold_out_r) == '0))
    else $error("press event on a key that is not held");

  // Row pointer does not move without an accepted beat.
  a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(cur_row_r))
    else $error("row pointer moved without a beat");

endmodule

FILE: hdl/kmsd_rowmem.sv
// Row state memory: press / release counts of one row per entry.
// One sync read port, one write port, per-row valid bits.
// Depends on kmsd_pkg.
`timescale 1ns / 1ps
module kmsd_rowmem #(
  parameter int NUM_ROWS = 4,
  parameter int WORD_W   = 32,
  parameter int ADDR_W   = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data
);
  import kmsd_pkg::*;

  logic [WORD_W-1:0]   mem [NUM_ROWS];
  logic [NUM_ROWS-1:0] vld_r;
  logic [WORD_W-1:0]   rd_data_r;
  logic                rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // Valid bits stand in for a clear: an unwritten row reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

FILE: hdl/kmsd_update.sv
// Debounce update of one row: counts, held flags and press events per column.
// Depends on kmsd_pkg.
`timescale 1ns / 1ps
module kmsd_update #(
  parameter int NUM_COLS = 4
) (
  input  logic [kmsd_pkg::LEVEL_W-1:0]     levels,
  input  logic [kmsd_pkg::CNT_W-1:0]       thr,
  input  logic [NUM_COLS*2*kmsd_pkg::CNT_W-1:0] word_in,
  input  logic [NUM_COLS-1:0]              held_in,
  output logic [NUM_COLS*2*kmsd_pkg::CNT_W-1:0] word_out,
  output logic [NUM_COLS-1:0]              held_out,
  output logic [NUM_COLS-1:0]              evt_out
);
  import kmsd_pkg::*;

  localparam int ENT_W = 2 * CNT_W;

  for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
    logic             high;
    logic [CNT_W-1:0] pc, rc, pc_inc, rc_inc;

    if (c < LEVEL_W) begin : g_lvl
      assign high = levels[c];
    end else begin : g_open
      assign high = 1'b1;    // no such column line: reads open
    end

    // entry layout: {release, press}
    assign pc     = word_in[c*ENT_W +: CNT_W];
    assign rc     = word_in[c*ENT_W + CNT_W +: CNT_W];
    assign pc_inc = pc + CNT_W'(1);
    assign rc_inc = rc + CNT_W'(1);

    always_comb begin
      word_out[c*ENT_W +: ENT_W] = '0;
      held_out[c] = held_in[c];
      evt_out[c]  = 1'b0;
      if (!high) begin
        if (pc_inc >= thr) begin
          held_out[c] = 1'b1;
          evt_out[c]  = !held_in[c];
        end else begin
          word_out[c*ENT_W +: CNT_W] = pc_inc;
        end
      end else begin
        if (rc_inc >= thr) begin
          held_out[c] = 1'b0;
        end else begin
          word_out[c*ENT_W + CNT_W +: CNT_W] = rc_inc;
        end
      end
    end
  end

endmodule
